// ----- design/qte_pkg.sv -----
// ----------------------------------------------------------------------------
// qte_pkg
// shared constants, types and the arctangent table for the quaternion to
// euler angle pipeline
// ----------------------------------------------------------------------------
package qte_pkg;

  localparam int CORDIC_STAGES = 16;
  localparam int ATAN_LEN      = 24;
  // stages past the table length do nothing, so they are not built
  localparam int NST = (CORDIC_STAGES < ATAN_LEN) ? CORDIC_STAGES : ATAN_LEN;

  localparam int TW  = 34;           // sum-of-products terms, q.28
  localparam int CW  = 38;           // cordic x and y
  localparam int ZW  = 24;           // cordic angle accumulator, q.20
  localparam int AW  = ZW - 7;       // rounded angle, q3.13
  localparam int RW  = 57;           // sqrt radicand
  localparam int QW  = 29;           // sqrt root
  localparam int SQRT_STAGES = QW;

  localparam int CORD_LAT = NST + 2;
  localparam int LAT      = 3 + SQRT_STAGES + CORD_LAT + 1;

  localparam logic signed [ZW-1:0] PI_Q20      = ZW'(3294199);
  localparam logic signed [AW-1:0] PI_Q13      = AW'(25736);
  localparam logic signed [AW-1:0] HALF_PI_Q13 = AW'(12868);
  localparam logic signed [TW-1:0] ONE_Q28     = TW'(268435456);

  typedef struct packed {
    logic signed [TW-1:0] sinr;
    logic signed [TW-1:0] cosr;
    logic signed [TW-1:0] siny;
    logic signed [TW-1:0] cosy;
    logic signed [TW-1:0] sinp;
    logic                 sat;
    logic                 sat_neg;
  } term_t;

  function automatic logic signed [ZW-1:0] atan_q20(input int i);
    logic signed [ZW-1:0] r;
    case (i)
      0:  r = ZW'(823550);
      1:  r = ZW'(486170);
      2:  r = ZW'(256879);
      3:  r = ZW'(130396);
      4:  r = ZW'(65451);
      5:  r = ZW'(32757);
      6:  r = ZW'(16383);
      7:  r = ZW'(8192);
      8:  r = ZW'(4096);
      9:  r = ZW'(2048);
      10: r = ZW'(1024);
      11: r = ZW'(512);
      12: r = ZW'(256);
      13: r = ZW'(128);
      14: r = ZW'(64);
      15: r = ZW'(32);
      16: r = ZW'(16);
      17: r = ZW'(8);
      18: r = ZW'(4);
      19: r = ZW'(2);
      20: r = ZW'(1);
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ----- design/qte_sqrt.sv -----
// ----------------------------------------------------------------------------
// qte_sqrt
// pipelined floor square root, one result bit per stage
// ----------------------------------------------------------------------------
module qte_sqrt import qte_pkg::*; (
  input  logic          clk,
  input  logic          en,
  input  logic [RW-1:0] rad,
  output logic [QW-1:0] root
);

  localparam int SW = RW + 1;

  logic [SW-1:0] vr [1:SQRT_STAGES];
  logic [SW-1:0] rr [1:SQRT_STAGES];

  for (genvar s = 0; s < SQRT_STAGES; s++) begin : g_stage
    logic [SW-1:0] cv;
    logic [SW-1:0] cr;
    logic [SW-1:0] trial;
    logic [SW-1:0] bitv;
    if (s == 0) begin : g_first
      assign cv = {1'b0, rad};
      assign cr = '0;
    end else begin : g_rest
      assign cv = vr[s];
      assign cr = rr[s];
    end
    assign bitv  = SW'(1) << (2 * (SQRT_STAGES - 1 - s));
    assign trial = cr + bitv;
    always_ff @(posedge clk) begin
      if (en) begin
        if (cv >= trial) begin
          vr[s+1] <= cv - trial;
          rr[s+1] <= (cr >> 1) + bitv;
        end else begin
          vr[s+1] <= cv;
          rr[s+1] <= cr >> 1;
        end
      end
    end
  end

  assign root = rr[SQRT_STAGES][QW-1:0];

endmodule

// ----- design/qte_cordic.sv -----
// ----------------------------------------------------------------------------
// qte_cordic
// pipelined vectoring cordic atan2, angle rounded to q3.13, not clamped
// ----------------------------------------------------------------------------
module qte_cordic import qte_pkg::*; (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [CW-1:0] y,
  input  logic signed [CW-1:0] x,
  output logic signed [AW-1:0] angle
);

  logic signed [CW-1:0] xr [0:NST];
  logic signed [CW-1:0] yr [0:NST];
  logic signed [ZW-1:0] zr [0:NST];
  logic                 zf [0:NST];
  logic signed [ZW-1:0] zsum;

  // left half plane folds over with a pi offset
  always_ff @(posedge clk) begin
    if (en) begin
      zf[0] <= (x == '0) && (y == '0);
      if (x < 0) begin
        xr[0] <= -x;
        yr[0] <= -y;
        zr[0] <= (y >= 0) ? PI_Q20 : -PI_Q20;
      end else begin
        xr[0] <= x;
        yr[0] <= y;
        zr[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < NST; i++) begin : g_stage
    logic signed [CW-1:0] xs;
    logic signed [CW-1:0] ys;
    assign xs = xr[i] >>> i;
    assign ys = yr[i] >>> i;
    always_ff @(posedge clk) begin
      if (en) begin
        zf[i+1] <= zf[i];
        if (yr[i] >= 0) begin
          xr[i+1] <= xr[i] + ys;
          yr[i+1] <= yr[i] - xs;
          zr[i+1] <= zr[i] + atan_q20(i);
        end else begin
          xr[i+1] <= xr[i] - ys;
          yr[i+1] <= yr[i] + xs;
          zr[i+1] <= zr[i] - atan_q20(i);
        end
      end
    end
  end

  assign zsum = zr[NST] + ZW'(64);

  always_ff @(posedge clk) begin
    if (en) begin
      angle <= zf[NST] ? '0 : zsum[ZW-1:7];
    end
  end

endmodule

// ----- design/quaternion_to_euler_zyx_core.sv -----
// ----------------------------------------------------------------------------
// quaternion_to_euler_zyx_core
// unit quaternion in q2.14 to roll, pitch and yaw (zyx order) in q3.13
// ----------------------------------------------------------------------------
// usage
//   input channel: quat_w/x/y/z with in_valid, in_stall; a transaction moves
//   when in_valid is high and in_stall is low at a rising edge
//   output channel: roll_angle, pitch_angle, yaw_angle with out_valid,
//   out_stall driven by the receiver
//   throughput: one transaction per cycle unless the pipeline is stalled,
//   every stage holds one item; the pipeline is three product/sum stages,
//   the 29-stage bit-per-stage square root on the pitch path, the cordic
//   lanes (one fold stage, one per iteration, one rounding stage) and the
//   clamp register
//   stall: while a result waits under out_stall the whole pipeline freezes
//   and in_stall is raised; nothing is dropped or repeated
//   reset: rst clears all valid bits; data registers are not reset
// ----------------------------------------------------------------------------
module quaternion_to_euler_zyx_core import qte_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] quat_w,
  input  logic signed [15:0] quat_x,
  input  logic signed [15:0] quat_y,
  input  logic signed [15:0] quat_z,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] roll_angle,
  output logic signed [14:0] pitch_angle,
  output logic signed [15:0] yaw_angle
);

  // pipeline advances unless a finished result is held by the receiver
  logic en;
  logic [LAT-1:0] vld;

  assign en        = !(vld[LAT-1] && out_stall);
  assign in_stall  = !en;
  assign out_valid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], in_valid};
    end
  end

  // stage 1: the nine products
  logic signed [31:0] pwx, pyz, pxx, pyy, pwy, pzx, pwz, pxy, pzz;

  always_ff @(posedge clk) begin
    if (en) begin
      pwx <= 32'(quat_w) * 32'(quat_x);
      pyz <= 32'(quat_y) * 32'(quat_z);
      pxx <= 32'(quat_x) * 32'(quat_x);
      pyy <= 32'(quat_y) * 32'(quat_y);
      pwy <= 32'(quat_w) * 32'(quat_y);
      pzx <= 32'(quat_z) * 32'(quat_x);
      pwz <= 32'(quat_w) * 32'(quat_z);
      pxy <= 32'(quat_x) * 32'(quat_y);
      pzz <= 32'(quat_z) * 32'(quat_z);
    end
  end

  // stage 2: sum-of-products terms in q.28
  logic signed [TW-1:0] sinr, cosr, siny, cosy, sinp;

  always_ff @(posedge clk) begin
    if (en) begin
      sinr <= (TW'(pwx) + TW'(pyz)) <<< 1;
      cosr <= ONE_Q28 - ((TW'(pxx) + TW'(pyy)) <<< 1);
      sinp <= (TW'(pwy) - TW'(pzx)) <<< 1;
      siny <= (TW'(pwz) + TW'(pxy)) <<< 1;
      cosy <= ONE_Q28 - ((TW'(pyy) + TW'(pzz)) <<< 1);
    end
  end

  // stage 3: pitch saturation test and the square of the pitch sine
  logic                 sat_c;
  logic [TW-1:0]        sinp_mag;
  logic [27:0]          sinp_abs;
  logic [55:0]          sq;
  logic [RW-1:0]        rad;
  term_t                tdly [0:SQRT_STAGES];

  assign sat_c    = (sinp >= ONE_Q28) || (sinp <= -ONE_Q28);
  assign sinp_mag = sinp[TW-1] ? TW'(-sinp) : TW'(sinp);
  // saturated terms feed a dummy zero, their pitch is overridden later
  assign sinp_abs = sat_c ? '0 : sinp_mag[27:0];

  always_ff @(posedge clk) begin
    if (en) begin
      sq              <= 56'(sinp_abs) * 56'(sinp_abs);
      tdly[0].sinr    <= sinr;
      tdly[0].cosr    <= cosr;
      tdly[0].siny    <= siny;
      tdly[0].cosy    <= cosy;
      tdly[0].sinp    <= sinp;
      tdly[0].sat     <= sat_c;
      tdly[0].sat_neg <= sinp[TW-1];
      // terms ride alongside the square root
      for (int k = 1; k <= SQRT_STAGES; k++) begin
        tdly[k] <= tdly[k-1];
      end
    end
  end

  // cosine of pitch as floor sqrt(1 - s*s) in q.28
  assign rad = {1'b1, 56'd0} - {1'b0, sq};

  logic [QW-1:0] cosp;

  qte_sqrt u_sqrt (
    .clk  (clk),
    .en   (en),
    .rad  (rad),
    .root (cosp)
  );

  // three cordic lanes in parallel
  logic signed [AW-1:0] roll_raw, pitch_raw, yaw_raw;
  term_t                tq;

  assign tq = tdly[SQRT_STAGES];

  qte_cordic u_roll (
    .clk   (clk),
    .en    (en),
    .y     (CW'(tq.sinr)),
    .x     (CW'(tq.cosr)),
    .angle (roll_raw)
  );

  qte_cordic u_pitch (
    .clk   (clk),
    .en    (en),
    .y     (CW'(tq.sinp)),
    .x     (CW'({1'b0, cosp})),
    .angle (pitch_raw)
  );

  qte_cordic u_yaw (
    .clk   (clk),
    .en    (en),
    .y     (CW'(tq.siny)),
    .x     (CW'(tq.cosy)),
    .angle (yaw_raw)
  );

  // saturation flags delayed to line up with the cordic results
  logic [1:0] sdly [0:CORD_LAT-1];

  always_ff @(posedge clk) begin
    if (en) begin
      sdly[0] <= {tq.sat, tq.sat_neg};
      for (int k = 1; k < CORD_LAT; k++) begin
        sdly[k] <= sdly[k-1];
      end
    end
  end

  // clamp and output register
  logic signed [AW-1:0] roll_c, pitch_c, yaw_c;
  logic                 sat_q, sat_neg_q;

  assign sat_q     = sdly[CORD_LAT-1][1];
  assign sat_neg_q = sdly[CORD_LAT-1][0];

  always_comb begin
    roll_c = roll_raw;
    if (roll_raw > PI_Q13) roll_c = PI_Q13;
    if (roll_raw < -PI_Q13) roll_c = -PI_Q13;
    yaw_c = yaw_raw;
    if (yaw_raw > PI_Q13) yaw_c = PI_Q13;
    if (yaw_raw < -PI_Q13) yaw_c = -PI_Q13;
    pitch_c = pitch_raw;
    if (pitch_raw > HALF_PI_Q13) pitch_c = HALF_PI_Q13;
    if (pitch_raw < -HALF_PI_Q13) pitch_c = -HALF_PI_Q13;
    if (sat_q) pitch_c = sat_neg_q ? -HALF_PI_Q13 : HALF_PI_Q13;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      roll_angle  <= roll_c[15:0];
      pitch_angle <= pitch_c[14:0];
      yaw_angle   <= yaw_c[15:0];
    end
  end

`ifndef SYNTHESIS
  a_pitch_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (pitch_angle <= 15'sd12868) && (pitch_angle >= -15'sd12868))
    else $error("pitch out of range");

  a_roll_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (roll_angle <= 16'sd25736) && (roll_angle >= -16'sd25736))
    else $error("roll out of range");

  a_pitch_sat: assert property (@(posedge clk) disable iff (rst)
    (en && vld[LAT-2] && sat_q) |=>
      (pitch_angle == 15'sd12868) || (pitch_angle == -15'sd12868))
    else $error("saturated pitch not at a pole");
`endif

endmodule

// ----- tb/euler_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// euler_checker
// watches both channels of the quaternion to euler core, computes the
// expected angles in fixed point and compares them with the results
// ----------------------------------------------------------------------------
module euler_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic signed [15:0] quat_w,
  input  logic signed [15:0] quat_x,
  input  logic signed [15:0] quat_y,
  input  logic signed [15:0] quat_z,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [15:0] roll_angle,
  input  logic signed [14:0] pitch_angle,
  input  logic signed [15:0] yaw_angle,
  output int                 fail_count,
  output int                 pending
);

  localparam int STAGES = 16;
  localparam longint ONE_Q28 = 64'sd1 << 28;
  localparam longint PI_Q20 = 3294199;
  localparam longint PI_Q13 = 25736;
  localparam longint HALF_PI_Q13 = 12868;

  typedef struct packed {
    logic signed [15:0] roll;
    logic signed [14:0] pitch;
    logic signed [15:0] yaw;
  } angles_t;

  angles_t angles_q[$];

  function automatic longint atan_entry(input int i);
    longint tbl [0:23] = '{823550, 486170, 256879, 130396, 65451, 32757, 16383,
                           8192, 4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8,
                           4, 2, 1, 0, 0, 0};
    return tbl[i];
  endfunction

  function automatic longint isqrt(input longint v);
    longint res;
    longint b;
    res = 0;
    b = 64'sd1 << 62;
    while (b > v) b = b >>> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >>> 1) + b;
      end else begin
        res = res >>> 1;
      end
      b = b >>> 2;
    end
    return res;
  endfunction

  // vectoring cordic, arithmetic shifts floor toward minus infinity
  function automatic longint vector_angle(input longint y, input longint x);
    longint z;
    longint xs;
    longint ys;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      z = (y >= 0) ? PI_Q20 : -PI_Q20;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < STAGES && i < 24; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys;
        y = y - xs;
        z = z + atan_entry(i);
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - atan_entry(i);
      end
    end
    return (z + 64) >>> 7;
  endfunction

  function automatic longint clip(input longint v, input longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic angles_t euler_of(input longint w, input longint x,
                                       input longint y, input longint z);
    angles_t a;
    longint sinp;
    sinp = 2 * (w * y - z * x);
    a.roll = 16'(clip(vector_angle(2 * (w * x + y * z),
                                   ONE_Q28 - 2 * (x * x + y * y)), PI_Q13));
    a.yaw = 16'(clip(vector_angle(2 * (w * z + x * y),
                                  ONE_Q28 - 2 * (y * y + z * z)), PI_Q13));
    if (sinp >= ONE_Q28) a.pitch = 15'(HALF_PI_Q13);
    else if (sinp <= -ONE_Q28) a.pitch = 15'(-HALF_PI_Q13);
    else a.pitch = 15'(clip(vector_angle(sinp, isqrt((64'sd1 << 56) - sinp * sinp)),
                            HALF_PI_Q13));
    return a;
  endfunction

  initial pending = 0;

  always @(posedge clk) begin
    angles_t exp_a;
    if (rst) begin
      fail_count <= 0;
    end else begin
      if (in_valid && !in_stall)
        angles_q.push_back(euler_of(quat_w, quat_x, quat_y, quat_z));
      if (out_valid && !out_stall) begin
        if (angles_q.size() == 0) begin
          if (fail_count < 10) $display("unexpected result transaction");
          fail_count <= fail_count + 1;
        end else begin
          exp_a = angles_q.pop_front();
          if (exp_a.roll !== roll_angle || exp_a.pitch !== pitch_angle ||
              exp_a.yaw !== yaw_angle) begin
            if (fail_count < 10)
              $display("mismatch: expected r=%0d p=%0d y=%0d got r=%0d p=%0d y=%0d",
                       exp_a.roll, exp_a.pitch, exp_a.yaw,
                       roll_angle, pitch_angle, yaw_angle);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
    // outstanding transactions, read by the top to know when to stop
    pending = angles_q.size();
  end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// stimulus and verdict for the quaternion to euler core: directed corner
// quaternions then random ones under varied idling on both channels
// ----------------------------------------------------------------------------
module tb;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_stall;
  logic signed [15:0] quat_w = 0, quat_x = 0, quat_y = 0, quat_z = 0;
  logic out_valid;
  logic out_stall = 0;
  logic signed [15:0] roll_angle;
  logic signed [14:0] pitch_angle;
  logic signed [15:0] yaw_angle;
  int fail_count;
  int pending;

  // idle percentages per side, changed between phases
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_off = 0;

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  quaternion_to_euler_zyx_core uut (.*);

  euler_checker chk (.*);

  // receiver stall, random per cycle unless a long hold-off is running
  always @(negedge clk) begin
    if (hold_off) out_stall <= 1;
    else out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // one transaction: optional idle gap, then hold valid until accepted
  task automatic send_quat(input logic [15:0] w, x, y, z);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid <= 1;
    quat_w <= w;
    quat_x <= x;
    quat_y <= y;
    quat_z <= z;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // random field, biased toward the unit range and the extremes
  function automatic logic [15:0] rand_comp();
    case ($urandom_range(9))
      0: return 16'($urandom);
      1: return $urandom_range(1) ? 16'h7fff : 16'h8000;
      2: return 16'($signed($urandom_range(40)) - 20);
      default: return 16'($signed($urandom_range(32768)) - 16384);
    endcase
  endfunction

  // roughly unit quaternion: pick three parts, solve for w
  task automatic send_unit();
    int x, y, z, s;
    real r;
    x = $signed($urandom_range(23170)) - 11585;
    y = $signed($urandom_range(23170)) - 11585;
    z = $signed($urandom_range(23170)) - 11585;
    s = x * x + y * y + z * z;
    r = (s < 268435456) ? $sqrt(268435456.0 - s) : 0.0;
    if ($urandom_range(1)) r = -r;
    send_quat(16'($rtoi(r)), 16'(x), 16'(y), 16'(z));
  endtask

  initial begin
    #200000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // directed: identity, axis rotations, gimbal lock both ways, extremes, zero
    send_quat(16384, 0, 0, 0);
    send_quat(0, 16384, 0, 0);
    send_quat(0, 0, 16384, 0);
    send_quat(0, 0, 0, 16384);
    send_quat(-16384, 0, 0, 0);
    send_quat(11585, 0, 11585, 0);
    send_quat(11585, 0, -11585, 0);
    send_quat(11585, 11585, 11585, -11585);
    send_quat(0, 0, 0, 0);
    send_quat(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
    send_quat(16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_quat(16'h7fff, 16'h8000, 16'h7fff, 16'h8000);
    send_quat(16'h5555, 16'haaaa, 16'haaaa, 16'h5555);
    send_quat(11585, 11585, 0, 0);
    send_quat(11585, -11585, 0, 0);
    send_quat(0, 11585, 0, 11585);
    send_quat(1, -1, 1, -1);

    // sender idles lightly, receiver heavily
    send_idle_pct = 20;
    recv_idle_pct = 83;
    repeat (300) if ($urandom_range(3) == 0) send_unit(); else
      send_quat(rand_comp(), rand_comp(), rand_comp(), rand_comp());

    // long receiver hold-off while items keep coming, to fill the pipeline
    send_idle_pct = 0;
    recv_idle_pct = 0;
    fork
      begin
        hold_off = 1;
        repeat (150) @(posedge clk);
        hold_off = 0;
      end
      repeat (100) send_unit();
    join

    send_idle_pct = 83;
    recv_idle_pct = 20;
    repeat (270) if ($urandom_range(3) == 0) send_unit(); else
      send_quat(rand_comp(), rand_comp(), rand_comp(), rand_comp());

    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (270) if ($urandom_range(1)) send_unit(); else
      send_quat(rand_comp(), rand_comp(), rand_comp(), rand_comp());
    in_valid <= 0;

    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (fail_count == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
